// File: src/spo_pkg.sv
// spo_pkg: shared types and sizing constants for the sphere pair overlap block.
// No dependencies.
`default_nettype none

package spo_pkg;

  localparam int MAX_SPHERES = 32;
  localparam int IDX_W       = $clog2(MAX_SPHERES);
  localparam int CNT_W       = $clog2(MAX_SPHERES + 1);

  localparam int COORD_W  = 24;
  localparam int RADIUS_W = 23;
  localparam int OUT_IDX_W = 6;

  localparam logic STATUS_PAIR = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic                       start_set;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [COORD_W-1:0]  pos_z;
    logic        [RADIUS_W-1:0] radius;
  } request_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] first_index;
    logic [OUT_IDX_W-1:0] second_index;
    logic                 status;
    logic                 last_of_run;
  } result_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
    logic        [RADIUS_W-1:0] r;
  } sphere_t;

endpackage

`default_nettype wire

// File: src/sphere_pair_overlap.sv
// sphere_pair_overlap: all-pairs bounding sphere overlap test, one shared multiplier.
// Depends on spo_pkg (types, sizing constants).
`default_nettype none

// Usage
//   Request channel: drive request and raise start; the request is taken at a
//   clock edge where start is high and busy is low. busy stays high while the
//   new sphere is tested against the stored set.
//   Result channel: each result sits on result for one cycle with result_valid
//   high. The receiver cannot stall; every strobe must be captured.
//   status = 1 marks a dropped sphere (set full); that single result comes out
//   the cycle after the request, and busy never rises.
//   Scan: with n spheres stored, busy stays high while each stored sphere
//   goes through the sequencer phases in turn (a memory read wait, then dx^2,
//   dy^2, dz^2 and (r_a + r_b)^2 through the one 25x25 multiplier, summed and
//   compared) and then through S_LAST. With an empty set busy does not rise.
//   Pair results are held back by one hit so that last_of_run can be set on
//   the final one; the last pair leaves in the cycle busy drops.
//   start_set in the request empties the set first; the sphere then gets
//   index zero and makes no pairs.
//   Reset (rst, synchronous, active high) empties the set and returns the
//   sequencer to idle. Sphere memory contents are not cleared.
module sphere_pair_overlap (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  spo_pkg::request_t   request,
  output logic                busy,
  output spo_pkg::result_t    result,
  output logic                result_valid
);
  import spo_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_LAST = 3'b100
  } state_t;

  // Per-entry schedule of the shared multiplier.
  localparam logic [2:0] PH_WAIT = 3'd0;  // memory read in flight
  localparam logic [2:0] PH_DX   = 3'd1;
  localparam logic [2:0] PH_DY   = 3'd2;
  localparam logic [2:0] PH_DZ   = 3'd3;
  localparam logic [2:0] PH_RS   = 3'd4;
  localparam logic [2:0] PH_SUM  = 3'd5;
  localparam logic [2:0] PH_CMP  = 3'd6;

  state_t               state;
  logic [2:0]           phase;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     run_n;      // index of the new sphere
  logic [IDX_W-1:0]     idx;        // stored sphere under test
  sphere_t              cur;        // new sphere
  sphere_t              rd;         // registered memory read
  sphere_t              mem [MAX_SPHERES];
  logic [24:0]          op;
  logic [49:0]          prod;
  logic [51:0]          acc;
  logic                 pend_valid;
  logic [IDX_W-1:0]     pend_idx;

  logic                 accept;
  logic [CNT_W-1:0]     n_eff;
  logic                 set_full;
  logic                 hit;
  logic                 last_entry;
  logic [24:0]          op_next;

  function automatic logic [24:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                           input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    return d[COORD_W] ? 25'(-d) : 25'(d);
  endfunction

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign n_eff    = request.start_set ? '0 : count;
  assign set_full = (n_eff >= CNT_W'(MAX_SPHERES));
  assign hit      = (acc <= {2'b00, prod});
  assign last_entry = ((CNT_W'(idx) + CNT_W'(1)) == run_n);

  // Operand select for the multiplier feed.
  always_comb begin
    case (phase)
      PH_DX:   op_next = abs_diff(cur.x, rd.x);
      PH_DY:   op_next = abs_diff(cur.y, rd.y);
      PH_DZ:   op_next = abs_diff(cur.z, rd.z);
      PH_RS:   op_next = 25'({1'b0, cur.r} + {1'b0, rd.r});
      default: op_next = op;
    endcase
  end

  // Sphere memory: one write port at request time, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && !set_full) begin
      mem[n_eff[IDX_W-1:0]] <= '{x: request.pos_x, y: request.pos_y,
                                 z: request.pos_z, r: request.radius};
    end
    rd <= mem[idx];
  end

  // Datapath: operand, product, accumulator.
  // Products trail the operand select through the op and prod registers:
  // dx^2 is on prod in PH_DZ, dz^2 in PH_SUM and the radius sum squared in PH_CMP.
  always_ff @(posedge clk) begin
    op   <= op_next;
    prod <= op * op;
    case (phase)
      PH_DZ:   acc <= {2'b00, prod};
      PH_RS,
      PH_SUM:  acc <= acc + {2'b00, prod};
      default: acc <= acc;
    endcase
    if (accept) begin
      cur <= '{x: request.pos_x, y: request.pos_y,
               z: request.pos_z, r: request.radius};
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_WAIT;
      count        <= '0;
      run_n        <= '0;
      idx          <= '0;
      pend_valid   <= 1'b0;
      pend_idx     <= '0;
      result_valid <= 1'b0;
      result       <= '0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pend_valid <= 1'b0;
            idx        <= '0;
            phase      <= PH_WAIT;
            run_n      <= n_eff;
            if (set_full) begin
              count        <= n_eff;
              result_valid <= 1'b1;
              result       <= '{first_index: '0, second_index: '0,
                                status: STATUS_FULL, last_of_run: 1'b1};
            end else begin
              count <= n_eff + CNT_W'(1);
              if (n_eff != '0) begin
                state <= S_CMP;
              end
            end
          end
        end
        S_CMP: begin
          if (phase == PH_CMP) begin
            if (hit) begin
              // Release the previous hit; this one waits to learn if it is last.
              if (pend_valid) begin
                result_valid <= 1'b1;
                result       <= '{first_index: OUT_IDX_W'(pend_idx),
                                  second_index: OUT_IDX_W'(run_n),
                                  status: STATUS_PAIR, last_of_run: 1'b0};
              end
              pend_valid <= 1'b1;
              pend_idx   <= idx;
            end
            phase <= PH_WAIT;
            if (last_entry) begin
              state <= S_LAST;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end else begin
            phase <= phase + 3'd1;
          end
        end
        S_LAST: begin
          if (pend_valid) begin
            result_valid <= 1'b1;
            result       <= '{first_index: OUT_IDX_W'(pend_idx),
                              second_index: OUT_IDX_W'(run_n),
                              status: STATUS_PAIR, last_of_run: 1'b1};
          end
          pend_valid <= 1'b0;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SPHERES))
    else $error("sphere count above capacity");

  a_full_after_req: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == STATUS_FULL |-> $past(accept))
    else $error("overflow result without a request");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == STATUS_PAIR |->
      result.first_index < result.second_index)
    else $error("pair index not below new index");

  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> CNT_W'(idx) < run_n)
    else $error("compare index beyond stored set");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_of_run |-> !busy)
    else $error("last result while still busy");

endmodule

`default_nettype wire

// File: test/sphere_pair_overlap_tb.sv
// sphere_pair_overlap_tb: self-checking bench for the sphere pair overlap block.
// Depends on spo_pkg and sphere_pair_overlap; a scoreboard class predicts the pair stream.
`default_nettype none

module sphere_pair_overlap_tb;
  import spo_pkg::*;

  // Keeps its own copy of the sphere set and predicts, for each accepted request,
  // the overlapping pairs (stored index, new index) or the one set-full result.
  class pair_scoreboard;
    longint     set_x[MAX_SPHERES];
    longint     set_y[MAX_SPHERES];
    longint     set_z[MAX_SPHERES];
    longint     set_r[MAX_SPHERES];
    int         set_count;
    result_t    pending_pairs[$];
    int         mismatches;

    function new();
      set_count  = 0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return pending_pairs.size();
    endfunction

    function void note_sphere(request_t req);
      longint  x, y, z, r, dx, dy, dz, rsum;
      int      hits[$];
      result_t res;
      x = longint'($signed(req.pos_x));
      y = longint'($signed(req.pos_y));
      z = longint'($signed(req.pos_z));
      r = longint'(req.radius);
      if (req.start_set)
        set_count = 0;
      if (set_count >= MAX_SPHERES) begin
        res.first_index  = '0;
        res.second_index = '0;
        res.status       = STATUS_FULL;
        res.last_of_run  = 1'b1;
        pending_pairs.insert(pending_pairs.size(), res);
        return;
      end
      for (int i = 0; i < set_count; i++) begin
        dx   = x - set_x[i];
        dy   = y - set_y[i];
        dz   = z - set_z[i];
        rsum = r + set_r[i];
        // touching counts: <= not <
        if (dx * dx + dy * dy + dz * dz <= rsum * rsum)
          hits.insert(hits.size(), i);
      end
      foreach (hits[j]) begin
        res.first_index  = OUT_IDX_W'(hits[j]);
        res.second_index = OUT_IDX_W'(set_count);
        res.status       = STATUS_PAIR;
        res.last_of_run  = (j == hits.size() - 1);
        pending_pairs.insert(pending_pairs.size(), res);
      end
      set_x[set_count] = x;
      set_y[set_count] = y;
      set_z[set_count] = z;
      set_r[set_count] = r;
      set_count++;
    endfunction

    function void check_pair(result_t got);
      result_t want;
      if (pending_pairs.size() == 0) begin
        $display("%0t: unexpected result first=%0d second=%0d status=%0d last=%0d",
                 $time, got.first_index, got.second_index, got.status, got.last_of_run);
        mismatches++;
        return;
      end
      want = pending_pairs.pop_front();
      if (got.first_index !== want.first_index || got.second_index !== want.second_index ||
          got.status !== want.status || got.last_of_run !== want.last_of_run) begin
        $display("%0t: mismatch expected first=%0d second=%0d status=%0d last=%0d",
                 $time, want.first_index, want.second_index, want.status, want.last_of_run);
        $display("%0t:          actual   first=%0d second=%0d status=%0d last=%0d",
                 $time, got.first_index, got.second_index, got.status, got.last_of_run);
        mismatches++;
      end
    endfunction
  endclass

  localparam int COORD_MAX   = 8388607;
  localparam int COORD_MIN   = -8388608;
  localparam int RADIUS_MAX  = 8388607;
  localparam int RANDOM_ITEMS = 460;
  // timeout for the whole run, several times the worst-case run length
  localparam longint RUN_LIMIT = 8_000_000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  result_t  result;
  logic     result_valid;

  pair_scoreboard board;

  // cluster used by well-formed random sets
  int cx, cy, cz, spread;
  int sent;

  sphere_pair_overlap DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .request      (request),
    .busy         (busy),
    .result       (result),
    .result_valid (result_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Monitor: a request is taken at a rising edge with start high and busy low;
  // a result is taken at every edge with result_valid high. Both sample the
  // pre-edge values, so ordering inside the time step does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid)
        board.check_pair(result);
      if (start && !busy)
        board.note_sphere(request);
    end
  end

  function automatic request_t make_sphere(bit s, int x, int y, int z, int r);
    request_t req;
    req.start_set = s;
    req.pos_x     = COORD_W'(x);
    req.pos_y     = COORD_W'(y);
    req.pos_z     = COORD_W'(z);
    req.radius    = RADIUS_W'(r);
    return req;
  endfunction

  // Present one request at the falling edge and hold it until busy is low at a
  // rising edge. start stays high; the caller decides whether to idle after.
  task automatic send_sphere(request_t req);
    @(negedge clk);
    request <= req;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Sender holds off until the block is idle and every predicted pair is out.
  task automatic drain_pairs();
    @(negedge clk);
    start <= 1'b0;
    while (busy || board.outstanding() != 0)
      @(negedge clk);
  endtask

  function automatic int jitter();
    return int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  function automatic request_t random_sphere(bit first);
    request_t req;
    bit       s;
    // a stray set start in mid-run breaks the sequence now and then
    s = first || ($urandom_range(0, 99) < 3);
    if ($urandom_range(0, 99) < 25) begin
      // noise: any coordinate and radius the fields allow
      req.start_set = s;
      req.pos_x     = COORD_W'($urandom());
      req.pos_y     = COORD_W'($urandom());
      req.pos_z     = COORD_W'($urandom());
      req.radius    = RADIUS_W'($urandom());
    end else begin
      req = make_sphere(s, cx + jitter(), cy + jitter(), cz + jitter(),
                        int'($urandom_range(0, spread)));
    end
    return req;
  endfunction

  initial begin
    int set_len;
    int gap;
    bit quiet;
    bit first_set;
    board = new();
    sent  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed requests ---
    // zero radius, coincident centers: distance 0 equals radius sum 0
    send_sphere(make_sphere(0, 0, 0, 0, 0));
    send_sphere(make_sphere(0, 0, 0, 0, 0));
    // start with a sphere: it takes index zero and pairs with nothing
    send_sphere(make_sphere(1, 0, 0, 0, 256));
    // exactly touching on x, then one LSB apart on y, then touching on -z
    send_sphere(make_sphere(0, 512, 0, 0, 256));
    send_sphere(make_sphere(0, 0, 513, 0, 256));
    send_sphere(make_sphere(0, 0, 0, -512, 256));
    // opposite corners with the largest radius miss each other; origin hits both
    send_sphere(make_sphere(1, COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX));
    send_sphere(make_sphere(0, COORD_MIN, COORD_MIN, COORD_MIN, RADIUS_MAX));
    send_sphere(make_sphere(0, 0, 0, 0, RADIUS_MAX));
    send_sphere(make_sphere(0, COORD_MAX, COORD_MIN, COORD_MAX, 0));
    send_sphere(make_sphere(0, -1, -1, -1, 1));
    send_sphere(make_sphere(0, 'h555555, 'h2AAAAA, 'h555555, 'h2AAAAA));
    send_sphere(make_sphere(0, 'hAAAAAA, 'h555555, 'hAAAAAA, 'h555555));
    // no new request until every pair so far has come out
    drain_pairs();

    // --- random sets ---
    sent      = 0;
    first_set = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      cx     = int'($urandom_range(0, 16000000)) - 8000000;
      cy     = int'($urandom_range(0, 16000000)) - 8000000;
      cz     = int'($urandom_range(0, 16000000)) - 8000000;
      spread = 1 << $urandom_range(4, 16);
      // the first set and about one in five fill to capacity or run past it to hit set full
      if (first_set || $urandom_range(0, 99) < 20)
        set_len = $urandom_range(MAX_SPHERES, MAX_SPHERES + 4);
      else
        set_len = $urandom_range(1, 20);
      if ($urandom_range(0, 99) < 5)
        drain_pairs();
      for (int k = 0; k < set_len; k++) begin
        quiet = (sent >= 200 && sent < 300);
        if (!quiet && $urandom_range(0, 99) < 31) begin
          gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 80) : $urandom_range(1, 3);
          idle_cycles(gap);
        end
        send_sphere(random_sphere(k == 0));
      end
      first_set = 1'b0;
    end

    // wait for the tail, then allow one full scan of the set for strays
    @(negedge clk);
    start <= 1'b0;
    while (board.outstanding() != 0)
      @(posedge clk);
    repeat (7 * MAX_SPHERES + 20) @(posedge clk);

    if (board.mismatches == 0 && board.outstanding() == 0)
      $display("sphere_pair_overlap_tb OK");
    else
      $display("sphere_pair_overlap_tb NOT OK");
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("%0t: timeout", $time);
    $display("sphere_pair_overlap_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
